// ----- rtl/cgrs_pkg.sv -----
package cgrs_pkg;

  // Store and grid dimensions.
  localparam int MAX_POINTS    = 1024;
  localparam int PT_AW         = $clog2(MAX_POINTS);
  localparam int CNT_W         = PT_AW + 1;
  localparam int UPRIGHT_BINS  = 5;
  localparam int AZIMUTH_BINS  = 720;
  localparam int NUM_CELLS     = UPRIGHT_BINS * AZIMUTH_BINS;
  localparam int CELL_W        = $clog2(NUM_CELLS + 1);
  localparam int BAND_W        = $clog2(UPRIGHT_BINS);
  localparam int BIN_W         = $clog2(AZIMUTH_BINS);
  localparam int NUM_W         = 16 + BAND_W;
  localparam int MAX_NEIGHBORS = 64;
  localparam int NB_W          = $clog2(MAX_NEIGHBORS + 1);
  localparam int NUM_SLOTS     = 9;

  // Azimuth unit.
  localparam int CORDIC_STEPS  = 14;
  localparam int CORDIC_W      = 36;

  // Function codes of an input beat.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_NEIGHBOR  = 2'd0;
  localparam logic [1:0] ST_BUILD     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_QUERY = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POSE_X = 2'd0;
  localparam logic [1:0] CFG_POSE_Y = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic [31:0] RADIUS_RESET = 32'd250000;

  // One result beat.
  typedef struct packed {
    logic [1:0]       status;
    logic [PT_AW-1:0] index;
    logic [CNT_W-1:0] count;
    logic             last;
    logic             trunc;
  } res_t;

  // Arctangent of 2^-i in units of 2^-16 turn.
  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cgrs_ram.sv -----
module cgrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/cylindrical_grid_radius_search_top.sv -----
// Fixed-radius neighbor search over points binned on a cylindrical grid.
// Commands enter on start_i with func_i and are taken when busy_o is low.
// A load stores one point and gives no result, except a
// store-full result when the store already holds 1024 points.
// A build scans the heights, clears the cell table, bins every point
// with the shared CORDIC and band divider, forms cell starts by a
// running sum and sorts the point list. It ends in one beat that
// carries the point count.
// A query tests each candidate point of the visited cells: the
// single squaring multiplier is used three times for each candidate. Each
// neighbor comes out as one beat, the last one flagged, with at most 64.
// A bad query gives one beat on the cycle after it is taken.
// Results are strobed by result_valid_o for exactly one cycle each; the
// receiver must take them. The configuration channel is always ready; the
// user must write it only while the block is idle; the block itself does not enforce this.
// After reset the store is empty, the grid is not valid and the registers
// hold their reset values; no clearing pass is needed.
module cylindrical_grid_radius_search_top
  import cgrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        func_i,
  input  logic signed [15:0] x_mm_i,
  input  logic signed [15:0] y_mm_i,
  input  logic signed [15:0] z_mm_i,
  input  logic [9:0]        query_point_i,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [9:0]        neighbor_index_o,
  output logic [10:0]       point_count_o,
  output logic              last_o,
  output logic              truncated_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MM_RD  = 5'd1;
  localparam logic [4:0] S_MM_CMP = 5'd2;
  localparam logic [4:0] S_CLR    = 5'd3;
  localparam logic [4:0] S_BIN_RD = 5'd4;
  localparam logic [4:0] S_BIN_LD = 5'd5;
  localparam logic [4:0] S_CORDIC = 5'd6;
  localparam logic [4:0] S_BAND   = 5'd7;
  localparam logic [4:0] S_CELL   = 5'd8;
  localparam logic [4:0] S_CNT_WR = 5'd9;
  localparam logic [4:0] S_PFX_RD = 5'd10;
  localparam logic [4:0] S_PFX_WR = 5'd11;
  localparam logic [4:0] S_SC_RD  = 5'd12;
  localparam logic [4:0] S_SC_CUR = 5'd13;
  localparam logic [4:0] S_SC_WR  = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;
  localparam logic [4:0] S_Q_LD   = 5'd16;
  localparam logic [4:0] S_Q_DIV  = 5'd17;
  localparam logic [4:0] S_Q_CELL = 5'd18;
  localparam logic [4:0] S_Q_BEG  = 5'd19;
  localparam logic [4:0] S_Q_END  = 5'd20;
  localparam logic [4:0] S_Q_PTR  = 5'd21;
  localparam logic [4:0] S_Q_IDX  = 5'd22;
  localparam logic [4:0] S_Q_PT   = 5'd23;
  localparam logic [4:0] S_Q_MX   = 5'd24;
  localparam logic [4:0] S_Q_MY   = 5'd25;
  localparam logic [4:0] S_Q_MZ   = 5'd26;
  localparam logic [4:0] S_Q_CMP  = 5'd27;

  // Control registers.
  logic [4:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              grid_valid_q, grid_valid_d;
  logic signed [15:0] hmin_q, hmin_d, hmax_q, hmax_d;
  logic [15:0]       pose_x_q, pose_x_d, pose_y_q, pose_y_d;
  logic [31:0]       radius_q, radius_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // Sequencer working registers.
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CELL_W-1:0] c_q, c_d;
  logic [3:0]        iter_q, iter_d;
  logic signed [CORDIC_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [15:0]       ang_q, ang_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [16:0]       den_q, den_d;
  logic [BAND_W-1:0] band_q, band_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic [15:0]       qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic [BAND_W-1:0] u_q, u_d;
  logic [CELL_W-1:0] lrem_q, lrem_d;
  logic [3:0]        k_q, k_d;
  logic [CNT_W-1:0]  p_q, p_d, end_q, end_d;
  logic [PT_AW-1:0]  j_q, j_d;
  logic signed [16:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic [35:0]       d2_q, d2_d;
  logic [NB_W-1:0]   n_q, n_d;
  logic              trunc_q, trunc_d;
  logic              pend_valid_q, pend_valid_d;
  logic [PT_AW-1:0]  pend_idx_q, pend_idx_d;

  // Memory ports.
  logic              pt_we;
  logic [PT_AW-1:0]  pt_raddr;
  logic [15:0]       x_rdata, y_rdata, z_rdata;
  logic              cell_we;
  logic [PT_AW-1:0]  cell_raddr;
  logic [CELL_W-1:0] cell_rdata;
  logic              start_we;
  logic [CELL_W-1:0] start_waddr, start_raddr;
  logic [CNT_W-1:0]  start_wdata, start_rdata;
  logic              cur_we;
  logic [CELL_W-1:0] cur_waddr, cur_raddr;
  logic [CNT_W-1:0]  cur_wdata, cur_rdata;
  logic              sort_we;
  logic [PT_AW-1:0]  sort_waddr, sort_raddr;
  logic [PT_AW-1:0]  sort_rdata;

  logic accept;
  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Point coordinate stores, written on load.
  cgrs_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i, .we_i(pt_we), .waddr_i(count_q[PT_AW-1:0]), .wdata_i(x_mm_i),
    .raddr_i(pt_raddr), .rdata_o(x_rdata));
  cgrs_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk_i, .we_i(pt_we), .waddr_i(count_q[PT_AW-1:0]), .wdata_i(y_mm_i),
    .raddr_i(pt_raddr), .rdata_o(y_rdata));
  cgrs_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_z_ram (
    .clk_i, .we_i(pt_we), .waddr_i(count_q[PT_AW-1:0]), .wdata_i(z_mm_i),
    .raddr_i(pt_raddr), .rdata_o(z_rdata));

  // Cell of each point, written while binning.
  cgrs_ram #(.WIDTH(CELL_W), .DEPTH(MAX_POINTS)) u_cell_ram (
    .clk_i, .we_i(cell_we), .waddr_i(i_q[PT_AW-1:0]), .wdata_i(cell_d),
    .raddr_i(cell_raddr), .rdata_o(cell_rdata));

  // Cell counts, then cell start offsets.
  cgrs_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CELLS + 1)) u_start_ram (
    .clk_i, .we_i(start_we), .waddr_i(start_waddr), .wdata_i(start_wdata),
    .raddr_i(start_raddr), .rdata_o(start_rdata));

  // Fill cursor of each cell during the sort.
  cgrs_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CELLS)) u_cur_ram (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .raddr_i(cur_raddr), .rdata_o(cur_rdata));

  // Point indexes sorted by cell.
  cgrs_ram #(.WIDTH(PT_AW), .DEPTH(MAX_POINTS)) u_sort_ram (
    .clk_i, .we_i(sort_we), .waddr_i(sort_waddr), .wdata_i(i_q[PT_AW-1:0]),
    .raddr_i(sort_raddr), .rdata_o(sort_rdata));

  // Shared CORDIC rotation step.
  logic signed [CORDIC_W-1:0] xs, ys, cx_step, cy_step;
  logic [15:0] ang_step;
  always_comb begin
    xs = cx_q >>> iter_q;
    ys = cy_q >>> iter_q;
    if (!cy_q[CORDIC_W-1] && (cy_q != '0)) begin
      cx_step  = cx_q + ys;
      cy_step  = cy_q - xs;
      ang_step = ang_q + atan_lut(iter_q);
    end else begin
      cx_step  = cx_q - ys;
      cy_step  = cy_q + xs;
      ang_step = ang_q - atan_lut(iter_q);
    end
  end

  // Offsets of a loaded point from the pose and from the lowest height.
  logic signed [16:0] bdx, bdy;
  logic [16:0] zdiff, hrange;
  logic signed [CORDIC_W-1:0] bx0, by0;
  always_comb begin
    bdx    = 17'({x_rdata[15], x_rdata}) - 17'({pose_x_q[15], pose_x_q});
    bdy    = 17'({y_rdata[15], y_rdata}) - 17'({pose_y_q[15], pose_y_q});
    zdiff  = 17'({z_rdata[15], z_rdata}) - 17'({hmin_q[15], hmin_q});
    hrange = 17'({hmax_q[15], hmax_q}) - 17'({hmin_q[15], hmin_q});
    bx0    = CORDIC_W'(bdx) <<< 16;
    by0    = CORDIC_W'(bdy) <<< 16;
  end

  // Azimuth bin and grid cell of the point being binned.
  logic [16+BIN_W-1:0] bin_prod;
  logic [BIN_W-1:0]    bin;
  logic [CELL_W-1:0]   cell_c;
  always_comb begin
    bin_prod = (16 + BIN_W)'(ang_q) * (16 + BIN_W)'(AZIMUTH_BINS);
    bin      = bin_prod[16+BIN_W-1:16];
    cell_c   = CELL_W'(band_q) * CELL_W'(AZIMUTH_BINS) + CELL_W'(bin);
  end

  // Neighbor cell of the current query slot: own row, row below, row above.
  logic [BIN_W-1:0]  l, lm, lp, col;
  logic [BAND_W-1:0] row;
  logic              slot_valid;
  logic [CELL_W-1:0] slot_cell;
  always_comb begin
    l  = lrem_q[BIN_W-1:0];
    lm = (l == '0) ? BIN_W'(AZIMUTH_BINS - 1) : l - 1'b1;
    lp = (l == BIN_W'(AZIMUTH_BINS - 1)) ? '0 : l + 1'b1;
    priority if (k_q < 4'd3) begin
      row        = u_q;
      slot_valid = 1'b1;
    end else if (k_q < 4'd6) begin
      row        = u_q - 1'b1;
      slot_valid = (u_q != '0);
    end else begin
      row        = u_q + 1'b1;
      slot_valid = (u_q != BAND_W'(UPRIGHT_BINS - 1));
    end
    unique case (k_q)
      4'd1, 4'd5, 4'd8: col = lm;
      4'd2, 4'd4, 4'd7: col = lp;
      default:          col = l;
    endcase
    slot_cell = CELL_W'(row) * CELL_W'(AZIMUTH_BINS) + CELL_W'(col);
  end

  // Shared squaring multiplier for the distance test.
  logic signed [16:0] mul_in;
  logic signed [33:0] mul_ext, sq;
  always_comb begin
    unique case (state_q)
      S_Q_MX:  mul_in = dx_q;
      S_Q_MY:  mul_in = dy_q;
      default: mul_in = dz_q;
    endcase
    mul_ext = 34'(mul_in);
    sq      = mul_ext * mul_ext;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    grid_valid_d = grid_valid_q;
    hmin_d       = hmin_q;
    hmax_d       = hmax_q;
    pose_x_d     = pose_x_q;
    pose_y_d     = pose_y_q;
    radius_d     = radius_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    i_d          = i_q;
    c_d          = c_q;
    iter_d       = iter_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    ang_d        = ang_q;
    rem_d        = rem_q;
    den_d        = den_q;
    band_d       = band_q;
    cell_d       = cell_q;
    acc_d        = acc_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    qz_d         = qz_q;
    u_d          = u_q;
    lrem_d       = lrem_q;
    k_d          = k_q;
    p_d          = p_q;
    end_d        = end_q;
    j_d          = j_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    dz_d         = dz_q;
    d2_d         = d2_q;
    n_d          = n_q;
    trunc_d      = trunc_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;

    pt_we       = 1'b0;
    pt_raddr    = i_q[PT_AW-1:0];
    cell_we     = 1'b0;
    cell_raddr  = i_q[PT_AW-1:0];
    start_we    = 1'b0;
    start_waddr = c_q;
    start_wdata = '0;
    start_raddr = c_q;
    cur_we      = 1'b0;
    cur_waddr   = c_q;
    cur_wdata   = acc_q;
    cur_raddr   = cell_rdata;
    sort_we     = 1'b0;
    sort_waddr  = cur_rdata[PT_AW-1:0];
    sort_raddr  = p_q[PT_AW-1:0];

    // Register writes must arrive only while idle; the block itself does not enforce this.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POSE_X: pose_x_d = cfg_data_i[15:0];
        CFG_POSE_Y: pose_y_d = cfg_data_i[15:0];
        CFG_RADIUS: radius_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD: begin
              if (count_q >= CNT_W'(MAX_POINTS)) begin
                res_valid_d = 1'b1;
                res_d       = '{status: ST_FULL, index: '0, count: '0,
                                last: 1'b1, trunc: 1'b0};
              end else begin
                pt_we        = 1'b1;
                count_d      = count_q + 1'b1;
                grid_valid_d = 1'b0;
              end
            end
            FUNC_BUILD: begin
              hmin_d = '0;
              hmax_d = '0;
              i_d    = '0;
              c_d    = '0;
              state_d = (count_q == '0) ? S_CLR : S_MM_RD;
            end
            FUNC_QUERY: begin
              if (!grid_valid_q || (CNT_W'(query_point_i) >= count_q)) begin
                res_valid_d = 1'b1;
                res_d       = '{status: ST_BAD_QUERY, index: '0, count: '0,
                                last: 1'b1, trunc: 1'b0};
              end else begin
                pt_raddr   = query_point_i;
                cell_raddr = query_point_i;
                state_d    = S_Q_LD;
              end
            end
            default: ;
          endcase
        end
      end

      // Height range over the stored points.
      S_MM_RD: begin
        state_d = S_MM_CMP;
      end
      S_MM_CMP: begin
        if (i_q == '0) begin
          hmin_d = $signed(z_rdata);
          hmax_d = $signed(z_rdata);
        end else begin
          if ($signed(z_rdata) < hmin_q) hmin_d = $signed(z_rdata);
          if ($signed(z_rdata) > hmax_q) hmax_d = $signed(z_rdata);
        end
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == count_q) begin
          c_d     = '0;
          state_d = S_CLR;
        end else begin
          state_d = S_MM_RD;
        end
      end

      // Clear the cell count table.
      S_CLR: begin
        start_we = 1'b1;
        if (c_q == CELL_W'(NUM_CELLS)) begin
          i_d   = '0;
          c_d   = '0;
          acc_d = '0;
          state_d = (count_q == '0) ? S_PFX_RD : S_BIN_RD;
        end else begin
          c_d = c_q + 1'b1;
        end
      end

      // Bin each point by height band and azimuth.
      S_BIN_RD: begin
        state_d = S_BIN_LD;
      end
      S_BIN_LD: begin
        rem_d  = NUM_W'(zdiff[15:0]) * NUM_W'(UPRIGHT_BINS);
        den_d  = hrange + 17'd1;
        band_d = '0;
        iter_d = '0;
        if (bdy == '0) begin
          ang_d   = bdx[16] ? 16'd32768 : 16'd0;
          state_d = S_BAND;
        end else if (bdx == '0) begin
          ang_d   = bdy[16] ? 16'd49152 : 16'd16384;
          state_d = S_BAND;
        end else begin
          if (bdx[16]) begin
            cx_d  = -bx0;
            cy_d  = -by0;
            ang_d = 16'd32768;
          end else begin
            cx_d  = bx0;
            cy_d  = by0;
            ang_d = 16'd0;
          end
          state_d = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cx_d   = cx_step;
        cy_d   = cy_step;
        ang_d  = ang_step;
        iter_d = iter_q + 1'b1;
        if (iter_q == 4'(CORDIC_STEPS - 1)) state_d = S_BAND;
      end
      S_BAND: begin
        if ((rem_q >= NUM_W'(den_q)) && (band_q != BAND_W'(UPRIGHT_BINS - 1))) begin
          rem_d  = rem_q - NUM_W'(den_q);
          band_d = band_q + 1'b1;
        end else begin
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        cell_d      = cell_c;
        cell_we     = 1'b1;
        start_raddr = cell_c + 1'b1;
        state_d     = S_CNT_WR;
      end
      S_CNT_WR: begin
        start_we    = 1'b1;
        start_waddr = cell_q + 1'b1;
        start_wdata = start_rdata + 1'b1;
        i_d         = i_q + 1'b1;
        if (i_q + 1'b1 == count_q) begin
          c_d     = '0;
          acc_d   = '0;
          state_d = S_PFX_RD;
        end else begin
          state_d = S_BIN_RD;
        end
      end

      // Running sum turns counts into cell starts.
      S_PFX_RD: begin
        cur_we      = 1'b1;
        start_raddr = c_q + 1'b1;
        state_d     = S_PFX_WR;
      end
      S_PFX_WR: begin
        start_we    = 1'b1;
        start_waddr = c_q + 1'b1;
        start_wdata = acc_q + start_rdata;
        acc_d       = acc_q + start_rdata;
        if (c_q == CELL_W'(NUM_CELLS - 1)) begin
          i_d     = '0;
          state_d = (count_q == '0) ? S_DONE : S_SC_RD;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_PFX_RD;
        end
      end

      // Place each point index at its cell cursor.
      S_SC_RD: begin
        state_d = S_SC_CUR;
      end
      S_SC_CUR: begin
        cell_d  = cell_rdata;
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        sort_we   = 1'b1;
        cur_we    = 1'b1;
        cur_waddr = cell_q;
        cur_wdata = cur_rdata + 1'b1;
        i_d       = i_q + 1'b1;
        state_d   = (i_q + 1'b1 == count_q) ? S_DONE : S_SC_RD;
      end
      S_DONE: begin
        grid_valid_d = 1'b1;
        res_valid_d  = 1'b1;
        res_d        = '{status: ST_BUILD, index: '0, count: count_q,
                         last: 1'b1, trunc: 1'b0};
        state_d      = S_IDLE;
      end

      // Query: split the point's cell into band and azimuth bin.
      S_Q_LD: begin
        qx_d    = x_rdata;
        qy_d    = y_rdata;
        qz_d    = z_rdata;
        lrem_d  = cell_rdata;
        u_d     = '0;
        state_d = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (lrem_q >= CELL_W'(AZIMUTH_BINS)) begin
          lrem_d = lrem_q - CELL_W'(AZIMUTH_BINS);
          u_d    = u_q + 1'b1;
        end else begin
          k_d          = '0;
          n_d          = '0;
          trunc_d      = 1'b0;
          pend_valid_d = 1'b0;
          state_d      = S_Q_CELL;
        end
      end
      S_Q_CELL: begin
        if (k_q == 4'(NUM_SLOTS)) begin
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = '{status: ST_NEIGHBOR, index: pend_idx_q, count: '0,
                            last: 1'b1, trunc: trunc_q};
          end
          state_d = S_IDLE;
        end else if (!slot_valid) begin
          k_d = k_q + 1'b1;
        end else begin
          start_raddr = slot_cell;
          state_d     = S_Q_BEG;
        end
      end
      S_Q_BEG: begin
        p_d         = start_rdata;
        start_raddr = slot_cell + 1'b1;
        state_d     = S_Q_END;
      end
      S_Q_END: begin
        end_d   = start_rdata;
        state_d = S_Q_PTR;
      end
      S_Q_PTR: begin
        if (p_q >= end_q) begin
          k_d     = k_q + 1'b1;
          state_d = S_Q_CELL;
        end else begin
          state_d = S_Q_IDX;
        end
      end
      S_Q_IDX: begin
        j_d      = sort_rdata;
        pt_raddr = sort_rdata;
        state_d  = S_Q_PT;
      end
      S_Q_PT: begin
        dx_d    = 17'({qx_q[15], qx_q}) - 17'({x_rdata[15], x_rdata});
        dy_d    = 17'({qy_q[15], qy_q}) - 17'({y_rdata[15], y_rdata});
        dz_d    = 17'({qz_q[15], qz_q}) - 17'({z_rdata[15], z_rdata});
        d2_d    = '0;
        state_d = S_Q_MX;
      end
      S_Q_MX: begin
        d2_d    = d2_q + 36'($unsigned(sq));
        state_d = S_Q_MY;
      end
      S_Q_MY: begin
        d2_d    = d2_q + 36'($unsigned(sq));
        state_d = S_Q_MZ;
      end
      S_Q_MZ: begin
        d2_d    = d2_q + 36'($unsigned(sq));
        state_d = S_Q_CMP;
      end
      // A hit sends out the one held back, since only the final hit is last.
      S_Q_CMP: begin
        if (d2_q < 36'(radius_q)) begin
          if (n_q < NB_W'(MAX_NEIGHBORS)) begin
            if (pend_valid_q) begin
              res_valid_d = 1'b1;
              res_d       = '{status: ST_NEIGHBOR, index: pend_idx_q, count: '0,
                              last: 1'b0, trunc: 1'b0};
            end
            pend_idx_d   = j_q;
            pend_valid_d = 1'b1;
            n_d          = n_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
        end
        p_d     = p_q + 1'b1;
        state_d = S_Q_PTR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      grid_valid_q <= 1'b0;
      hmin_q       <= '0;
      hmax_q       <= '0;
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      radius_q     <= RADIUS_RESET;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      grid_valid_q <= grid_valid_d;
      hmin_q       <= hmin_d;
      hmax_q       <= hmax_d;
      pose_x_q     <= pose_x_d;
      pose_y_q     <= pose_y_d;
      radius_q     <= radius_d;
      res_valid_q  <= res_valid_d;
      res_q        <= res_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Working registers, set before use.
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    c_q        <= c_d;
    iter_q     <= iter_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    ang_q      <= ang_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    band_q     <= band_d;
    cell_q     <= cell_d;
    acc_q      <= acc_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    qz_q       <= qz_d;
    u_q        <= u_d;
    lrem_q     <= lrem_d;
    k_q        <= k_d;
    p_q        <= p_d;
    end_q      <= end_d;
    j_q        <= j_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    dz_q       <= dz_d;
    d2_q       <= d2_d;
    n_q        <= n_d;
    trunc_q    <= trunc_d;
    pend_idx_q <= pend_idx_d;
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_q.status;
  assign neighbor_index_o = res_q.index;
  assign point_count_o    = res_q.count;
  assign last_o           = res_q.last;
  assign truncated_o      = res_q.trunc;

  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store capacity");

  // Truncation is flagged only on the final neighbor beat.
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && truncated_o) |-> (last_o && status_o == ST_NEIGHBOR))
    else $error("truncation flag on a beat that is not the last neighbor");

  // A build result leaves a valid grid and an idle block.
  a_build_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_BUILD) |-> (grid_valid_q && !busy_o && last_o))
    else $error("build result without a valid grid");

  // Neighbor beats only come from a query that holds at least one hit.
  a_neighbor_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_NEIGHBOR) |-> $past(n_q != '0))
    else $error("neighbor beat without a recorded hit");

endmodule

// ----- test/cylindrical_grid_radius_search_top_tb.sv -----
module cylindrical_grid_radius_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgrs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int ATAN_STEP [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                              81, 41, 20, 10, 5, 3, 1};

  typedef struct {
    logic [1:0]        func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [9:0]        qp;
  } cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        func_i = FUNC_LOAD;
  logic signed [15:0] x_mm_i = '0;
  logic signed [15:0] y_mm_i = '0;
  logic signed [15:0] z_mm_i = '0;
  logic [9:0]        query_point_i = '0;
  logic              result_valid_o;
  logic [1:0]        status_o;
  logic [9:0]        neighbor_index_o;
  logic [10:0]       point_count_o;
  logic              last_o;
  logic              truncated_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = CFG_POSE_X;
  logic [31:0]       cfg_data_i = '0;

  cylindrical_grid_radius_search_top uut (.*);

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the block's point store, grid and registers.
  int pt_x [MAX_POINTS];
  int pt_y [MAX_POINTS];
  int pt_z [MAX_POINTS];
  int pt_cell [MAX_POINTS];
  int cell_start [NUM_CELLS+1];
  int sorted_pts [MAX_POINTS];
  int n_stored = 0;
  int h_min = 0;
  int h_max = 0;
  bit grid_ok = 1'b0;
  int pose_x = 0;
  int pose_y = 0;
  logic [31:0] radius_sq = RADIUS_RESET;

  res_t expected_beats[$];
  cmd_t pending_cmds[$];
  cmd_t cur_cmd;
  int n_queued = 0;
  int n_accepted = 0;
  int gen_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_left = 0;

  function automatic void push_beat(logic [1:0] st, int idx, int cnt, bit fin, bit tr);
    res_t b;
    b.status = st;
    b.index  = idx[PT_AW-1:0];
    b.count  = cnt[CNT_W-1:0];
    b.last   = fin;
    b.trunc  = tr;
    expected_beats.push_back(b);
  endfunction

  // Angle of (dx, dy) in 2^-16 turn by vectoring CORDIC.
  function automatic int azimuth_turns(int dx, int dy);
    longint x, y, xs, ys;
    int a, i;
    if (dy == 0) return (dx < 0) ? 32768 : 0;
    if (dx == 0) return (dy > 0) ? 16384 : 49152;
    x = longint'(dx) * 65536;
    y = longint'(dy) * 65536;
    a = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 32768;
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        a += ATAN_STEP[i];
      end else begin
        x -= ys;
        y += xs;
        a -= ATAN_STEP[i];
      end
    end
    return a & 32'hFFFF;
  endfunction

  // Height range, cell of every point, then a counting sort by cell.
  function automatic void rebuild_grid();
    int cursor [NUM_CELLS];
    int i, c, band, bin;
    longint num, den;
    h_min = 0;
    h_max = 0;
    if (n_stored > 0) begin
      h_min = pt_z[0];
      h_max = pt_z[0];
      for (i = 1; i < n_stored; i++) begin
        if (pt_z[i] < h_min) h_min = pt_z[i];
        if (pt_z[i] > h_max) h_max = pt_z[i];
      end
    end
    for (c = 0; c <= NUM_CELLS; c++) cell_start[c] = 0;
    for (i = 0; i < n_stored; i++) begin
      num  = longint'(pt_z[i] - h_min) * UPRIGHT_BINS;
      den  = longint'(h_max - h_min) + 1;
      band = int'(num / den);
      bin  = (azimuth_turns(pt_x[i] - pose_x, pt_y[i] - pose_y) * AZIMUTH_BINS) >> 16;
      if (band >= UPRIGHT_BINS) band = UPRIGHT_BINS - 1;
      if (bin >= AZIMUTH_BINS) bin = AZIMUTH_BINS - 1;
      pt_cell[i] = band * AZIMUTH_BINS + bin;
      cell_start[pt_cell[i] + 1]++;
    end
    for (c = 0; c < NUM_CELLS; c++) begin
      cell_start[c+1] += cell_start[c];
      cursor[c] = cell_start[c];
    end
    for (i = 0; i < n_stored; i++) begin
      sorted_pts[cursor[pt_cell[i]]] = i;
      cursor[pt_cell[i]]++;
    end
    grid_ok = 1'b1;
  endfunction

  // Neighbors of one point over its own and adjacent cells.
  function automatic void neighbors_of(int q);
    int cells [9];
    int u, l, lm, lp, nc, n, k, p, j;
    longint dx, dy, dz;
    longint unsigned d2;
    bit tr;
    if (!grid_ok || q >= n_stored) begin
      push_beat(ST_BAD_QUERY, 0, 0, 1'b1, 1'b0);
      return;
    end
    u  = pt_cell[q] / AZIMUTH_BINS;
    l  = pt_cell[q] % AZIMUTH_BINS;
    lm = (l == 0) ? AZIMUTH_BINS - 1 : l - 1;
    lp = (l == AZIMUTH_BINS - 1) ? 0 : l + 1;
    nc = 0;
    cells[nc++] = u * AZIMUTH_BINS + l;
    cells[nc++] = u * AZIMUTH_BINS + lm;
    cells[nc++] = u * AZIMUTH_BINS + lp;
    if (u > 0) begin
      cells[nc++] = (u - 1) * AZIMUTH_BINS + l;
      cells[nc++] = (u - 1) * AZIMUTH_BINS + lp;
      cells[nc++] = (u - 1) * AZIMUTH_BINS + lm;
    end
    if (u + 1 < UPRIGHT_BINS) begin
      cells[nc++] = (u + 1) * AZIMUTH_BINS + l;
      cells[nc++] = (u + 1) * AZIMUTH_BINS + lp;
      cells[nc++] = (u + 1) * AZIMUTH_BINS + lm;
    end
    n  = 0;
    tr = 1'b0;
    for (k = 0; k < nc; k++) begin
      for (p = cell_start[cells[k]]; p < cell_start[cells[k] + 1]; p++) begin
        j  = sorted_pts[p];
        dx = longint'(pt_x[q]) - pt_x[j];
        dy = longint'(pt_y[q]) - pt_y[j];
        dz = longint'(pt_z[q]) - pt_z[j];
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < {32'd0, radius_sq}) begin
          if (n < MAX_NEIGHBORS) begin
            push_beat(ST_NEIGHBOR, j, 0, 1'b0, 1'b0);
            n++;
          end else begin
            tr = 1'b1;
          end
        end
      end
    end
    if (n > 0) begin
      expected_beats[expected_beats.size()-1].last  = 1'b1;
      expected_beats[expected_beats.size()-1].trunc = tr;
    end
  endfunction

  function automatic void predict_cmd(cmd_t c);
    case (c.func)
      FUNC_LOAD: begin
        if (n_stored >= MAX_POINTS) begin
          push_beat(ST_FULL, 0, 0, 1'b1, 1'b0);
        end else begin
          pt_x[n_stored] = c.x;
          pt_y[n_stored] = c.y;
          pt_z[n_stored] = c.z;
          pt_cell[n_stored] = 0;
          n_stored++;
          grid_ok = 1'b0;
        end
      end
      FUNC_BUILD: begin
        rebuild_grid();
        push_beat(ST_BUILD, 0, n_stored, 1'b1, 1'b0);
      end
      FUNC_QUERY: neighbors_of(c.qp);
      default: ;
    endcase
  endfunction

  // Command driver: one beat per queued command, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left = 0;
    end else begin
      fire = start_i && !busy_o;
      if (fire) begin
        predict_cmd(cur_cmd);
        n_accepted++;
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (!start_i || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          func_i        <= cur_cmd.func;
          x_mm_i        <= cur_cmd.x;
          y_mm_i        <= cur_cmd.y;
          z_mm_i        <= cur_cmd.z;
          query_point_i <= cur_cmd.qp;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected st=%0d idx=%0d cnt=%0d last=%0b tr=%0b, got st=%0d idx=%0d cnt=%0d last=%0b tr=%0b",
               $realtime, what, want.status, want.index, want.count, want.last, want.trunc,
               got.status, got.index, got.count, got.last, got.trunc);
  endfunction

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cylindrical_grid_radius_search_top_tb: errors");
        $finish;
      end else if (result_valid_o) begin
        got = '{status_o, neighbor_index_o, point_count_o, last_o, truncated_o};
        if (expected_beats.size() == 0) begin
          flag_mismatch("unexpected beat", got, got);
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.count !== want.count || got.last !== want.last ||
              got.trunc !== want.trunc)
            flag_mismatch("beat mismatch", want, got);
        end
      end
    end
  end

  // Command builders.
  function automatic void queue_cmd(logic [1:0] f, int x, int y, int z, int qp);
    cmd_t c;
    c.func = f;
    c.x    = x[15:0];
    c.y    = y[15:0];
    c.z    = z[15:0];
    c.qp   = qp[9:0];
    pending_cmds.push_back(c);
    n_queued++;
    if (f == FUNC_LOAD && gen_count < MAX_POINTS) gen_count++;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void load_cluster(int n, int cx, int cy, int cz, int spread);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        queue_cmd(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom);
      else
        queue_cmd(FUNC_LOAD, clamp16(cx + $urandom_range(0, 2 * spread) - spread),
                  clamp16(cy + $urandom_range(0, 2 * spread) - spread),
                  clamp16(cz + $urandom_range(0, 2 * spread) - spread), $urandom);
    end
  endfunction

  function automatic void random_queries(int n);
    int i, r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0)
        queue_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
      else if (r == 1 || gen_count == 0)
        queue_cmd(FUNC_QUERY, $urandom, $urandom, $urandom, $urandom);
      else
        queue_cmd(FUNC_QUERY, $urandom, $urandom, $urandom, $urandom_range(0, gen_count - 1));
    end
  endfunction

  // Wait until every command is taken, every beat has come and the block is idle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (n_accepted != n_queued || expected_beats.size() != 0);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // One register beat; the caller starts at a clock edge and lowers valid afterwards.
  task automatic set_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_POSE_X: pose_x = $signed(data[15:0]);
      CFG_POSE_Y: pose_y = $signed(data[15:0]);
      CFG_RADIUS: radius_sq = data;
      default: ;
    endcase
  endtask

  task automatic configure(int px, int py, logic [31:0] rad);
    wait_idle();
    @(posedge clk_i);
    set_reg(CFG_POSE_X, px);
    set_reg(CFG_POSE_Y, py);
    set_reg(CFG_RADIUS, rad);
    if ($urandom_range(0, 1) == 0) set_reg(CFG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Phase: loads mostly around a cluster, a build, then queries, some unused or out of range.
  task automatic run_phase(int px, int py, logic [31:0] rad);
    int cx, cy, cz;
    configure(px, py, rad);
    cx = $urandom_range(0, 6000) - 3000;
    cy = $urandom_range(0, 6000) - 3000;
    cz = $urandom_range(0, 2000) - 1000;
    load_cluster($urandom_range(12, 20), cx, cy, cz, $urandom_range(150, 800));
    queue_cmd(FUNC_BUILD, 0, 0, 0, 0);
    random_queries($urandom_range(8, 12));
    if ($urandom_range(0, 2) == 0) begin
      load_cluster(1, cx, cy, cz, 300);
      random_queries(2);
      queue_cmd(FUNC_BUILD, 0, 0, 0, 0);
      random_queries(2);
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad queries, empty build, unused function, axis and extreme points.
    queue_cmd(FUNC_QUERY, 0, 0, 0, 0);
    queue_cmd(FUNC_BUILD, 0, 0, 0, 0);
    queue_cmd(FUNC_UNUSED, -1, -1, -1, 1023);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 0);
    queue_cmd(FUNC_LOAD, 0, 0, 0, 0);
    queue_cmd(FUNC_LOAD, 100, 0, 5, 0);
    queue_cmd(FUNC_LOAD, -100, 0, 5, 0);
    queue_cmd(FUNC_LOAD, 0, 100, 10, 0);
    queue_cmd(FUNC_LOAD, 0, -100, 10, 0);
    queue_cmd(FUNC_LOAD, 50, 50, 0, 0);
    queue_cmd(FUNC_LOAD, -50, -60, 3, 0);
    queue_cmd(FUNC_LOAD, 60, -40, -2, 0);
    queue_cmd(FUNC_LOAD, 32767, 32767, 32767, 0);
    queue_cmd(FUNC_LOAD, -32768, -32768, -32768, 0);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 0);
    queue_cmd(FUNC_BUILD, 0, 0, 0, 0);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 0);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 2);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 6);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 8);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 10);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 1023);
    queue_cmd(FUNC_LOAD, 10, 10, 10, 0);
    queue_cmd(FUNC_QUERY, 0, 0, 0, 1);
    queue_cmd(FUNC_BUILD, 0, 0, 0, 0);

    // Random phases across register settings, the extremes among them.
    run_phase(32767, -32768, 32'd0);
    run_phase(-32768, 32767, 32'hFFFF_FFFF);
    run_phase(1234, -777, 32'd90000);
    run_phase($urandom, $urandom, $urandom_range(10000, 4000000));
    run_phase(-300, 200, 32'd1000000);

    // Fill the store along a narrow ray so queries overflow the neighbor cap.
    configure(0, 0, 32'hFFFF_FFFF);
    while (gen_count < MAX_POINTS)
      queue_cmd(FUNC_LOAD, 20000 + $urandom_range(0, 4000), $urandom_range(0, 120) - 60,
                $urandom_range(0, 2000) - 1000, 0);
    queue_cmd(FUNC_LOAD, $urandom, $urandom, $urandom, 0);
    queue_cmd(FUNC_UNUSED, 0, 0, 0, 0);
    queue_cmd(FUNC_BUILD, 0, 0, 0, 0);
    for (i = 0; i < 4; i++) queue_cmd(FUNC_QUERY, 0, 0, 0, $urandom_range(200, 1023));
    queue_cmd(FUNC_QUERY, 0, 0, 0, 0);

    wait_idle();
    if (expected_beats.size() != 0) begin
      mismatches += expected_beats.size();
      $display("%0d expected beats never arrived", expected_beats.size());
    end
    if (mismatches == 0)
      $display("cylindrical_grid_radius_search_top_tb: clean");
    else
      $display("cylindrical_grid_radius_search_top_tb: errors");
    $finish;
  end

endmodule
